FILE: src/bced_pkg.sv
// ============================================================================
// bced_pkg
// Shared types and constants for the button click event detector.
// ============================================================================
package bced_pkg;

    // Field widths
    localparam int unsigned TimeW   = 32;
    localparam int unsigned ThreshW = 16;
    localparam int unsigned CountW  = 32;
    localparam int unsigned EventW  = 3;
    localparam int unsigned AddrW   = 4;
    localparam int unsigned DataW   = 32;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] RegDebounce  = 2'd0;
    localparam logic [1:0] RegLongPress = 2'd1;
    localparam logic [1:0] RegDblWindow = 2'd2;
    localparam logic [1:0] RegActiveLow = 2'd3;

    // Register reset values
    localparam logic [ThreshW-1:0] DebounceRst  = 16'd20;
    localparam logic [ThreshW-1:0] LongPressRst = 16'd1000;
    localparam logic [ThreshW-1:0] DblWindowRst = 16'd300;

    // Event codes
    typedef enum logic [EventW-1:0] {
        EV_NONE   = 3'd0,
        EV_DOWN   = 3'd1,
        EV_CLICK  = 3'd2,
        EV_DOUBLE = 3'd3,
        EV_LONG   = 3'd4
    } t_event_e;

    // Configuration seen by the detector
    typedef struct packed {
        logic [ThreshW-1:0] debounce_time;
        logic [ThreshW-1:0] long_press_time;
        logic [ThreshW-1:0] double_click_window;
        logic               active_low;
    } t_cfg;

    // One registered button sample
    typedef struct packed {
        logic             pin_level;
        logic [TimeW-1:0] time_ms;
        logic             clear_counts;
    } t_sample;

endpackage

FILE: src/bced_apb_regs.sv
// ============================================================================
// bced_apb_regs
// APB register file: thresholds and pin polarity.
// ============================================================================
module bced_apb_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bced_pkg::AddrW-1:0]  paddr,
    input  logic [bced_pkg::DataW-1:0]  pwdata,
    output logic [bced_pkg::DataW-1:0]  prdata,
    output logic                        pready,
    output bced_pkg::t_cfg              o_cfg
);

    bced_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    // Register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_time       <= bced_pkg::DebounceRst;
            r_cfg.long_press_time     <= bced_pkg::LongPressRst;
            r_cfg.double_click_window <= bced_pkg::DblWindowRst;
            r_cfg.active_low          <= 1'b1;
        end else if (wr_en) begin
            unique case (reg_idx)
                bced_pkg::RegDebounce:  r_cfg.debounce_time <= pwdata[15:0];
                bced_pkg::RegLongPress: r_cfg.long_press_time <= pwdata[15:0];
                bced_pkg::RegDblWindow: r_cfg.double_click_window <= pwdata[15:0];
                bced_pkg::RegActiveLow: r_cfg.active_low <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            bced_pkg::RegDebounce:  prdata = {16'd0, r_cfg.debounce_time};
            bced_pkg::RegLongPress: prdata = {16'd0, r_cfg.long_press_time};
            bced_pkg::RegDblWindow: prdata = {16'd0, r_cfg.double_click_window};
            bced_pkg::RegActiveLow: prdata = {31'd0, r_cfg.active_low};
            default:                prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/bced_in_stage.sv
// ============================================================================
// bced_in_stage
// Input register: holds one button sample until the detector takes it.
// ============================================================================
module bced_in_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_pin_level,
    input  logic [bced_pkg::TimeW-1:0]  i_time_ms,
    input  logic                        i_clear_counts,
    output logic                        o_vld,
    output bced_pkg::t_sample           o_sample,
    input  logic                        i_take
);

    logic              r_vld;
    bced_pkg::t_sample r_sample;

    // Free when empty or when the held sample leaves this cycle
    assign o_ready = ~r_vld | i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    // Sample payload, loaded on each transfer
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_sample.pin_level    <= i_pin_level;
            r_sample.time_ms      <= i_time_ms;
            r_sample.clear_counts <= i_clear_counts;
        end
    end

    assign o_vld    = r_vld;
    assign o_sample = r_sample;

endmodule

FILE: src/bced_core.sv
// ============================================================================
// bced_core
// Click state machine, event counters and result register.
// ============================================================================
module bced_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bced_pkg::t_cfg              i_cfg,
    input  logic                        i_vld,
    input  bced_pkg::t_sample           i_sample,
    output logic                        o_take,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [bced_pkg::EventW-1:0] o_event_code,
    output logic [bced_pkg::CountW-1:0] o_click_total,
    output logic [bced_pkg::CountW-1:0] o_double_click_total,
    output logic [bced_pkg::CountW-1:0] o_long_press_total
);

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_PRESSED  = 2'd2,
        PH_WAIT     = 2'd3
    } t_phase_e;

    t_phase_e                    r_phase, n_phase;
    logic [bced_pkg::TimeW-1:0]  r_mark, n_mark;
    logic [bced_pkg::TimeW-1:0]  r_start, n_start;
    logic                        r_pending, n_pending;
    logic                        r_dbl_conf, n_dbl_conf;
    logic [bced_pkg::CountW-1:0] r_click, n_click;
    logic [bced_pkg::CountW-1:0] r_double, n_double;
    logic [bced_pkg::CountW-1:0] r_long, n_long;
    logic                        r_out_vld;
    bced_pkg::t_event_e          r_event, n_event;

    logic                        pressed;
    logic [bced_pkg::TimeW-1:0]  since_mark;
    logic [bced_pkg::TimeW-1:0]  since_start;
    logic                        debounce_done;
    logic                        window_done;
    logic                        long_hold;
    logic [bced_pkg::CountW-1:0] base_click, base_double, base_long;

    // Take a sample when the result register is free or being drained
    assign o_take = i_vld & (~r_out_vld | i_ready);

    // Active-high press and wrapping elapsed times
    assign pressed       = i_sample.pin_level ^ i_cfg.active_low;
    assign since_mark    = i_sample.time_ms - r_mark;
    assign since_start   = i_sample.time_ms - r_start;
    assign debounce_done = since_mark  >= {16'd0, i_cfg.debounce_time};
    assign window_done   = since_mark  >= {16'd0, i_cfg.double_click_window};
    assign long_hold     = since_start >= {16'd0, i_cfg.long_press_time};

    // Clear comes before any count of this step
    assign base_click  = i_sample.clear_counts ? '0 : r_click;
    assign base_double = i_sample.clear_counts ? '0 : r_double;
    assign base_long   = i_sample.clear_counts ? '0 : r_long;

    // Next state for one sample
    always_comb begin
        n_phase    = r_phase;
        n_mark     = r_mark;
        n_start    = r_start;
        n_pending  = r_pending;
        n_dbl_conf = r_dbl_conf;
        n_click    = base_click;
        n_double   = base_double;
        n_long     = base_long;
        n_event    = bced_pkg::EV_NONE;
        unique case (r_phase)
            PH_IDLE: begin
                if (pressed) begin
                    n_phase = PH_DEBOUNCE;
                    n_mark  = i_sample.time_ms;
                end
            end
            PH_DEBOUNCE: begin
                if (debounce_done) begin
                    if (pressed) begin
                        n_phase = PH_PRESSED;
                        n_start = i_sample.time_ms;
                        n_event = bced_pkg::EV_DOWN;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            PH_PRESSED: begin
                if (!pressed) begin
                    if (long_hold) begin
                        n_long     = base_long + 1'b1;
                        n_event    = bced_pkg::EV_LONG;
                        n_dbl_conf = 1'b0;
                        n_phase    = PH_IDLE;
                    end else if (r_dbl_conf) begin
                        // release after a double click is absorbed
                        n_dbl_conf = 1'b0;
                        n_phase    = PH_IDLE;
                    end else begin
                        n_phase   = PH_WAIT;
                        n_mark    = i_sample.time_ms;
                        n_pending = 1'b1;
                    end
                end
            end
            PH_WAIT: begin
                if (pressed) begin
                    if (r_pending) begin
                        n_double   = base_double + 1'b1;
                        n_pending  = 1'b0;
                        n_dbl_conf = 1'b1;
                        n_event    = bced_pkg::EV_DOUBLE;
                    end
                    n_phase = PH_PRESSED;
                    n_start = i_sample.time_ms;
                end else if (window_done) begin
                    if (r_pending) begin
                        n_click   = base_click + 1'b1;
                        n_event   = bced_pkg::EV_CLICK;
                        n_pending = 1'b0;
                    end
                    n_phase = PH_IDLE;
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    // State, counters and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_mark     <= '0;
            r_start    <= '0;
            r_pending  <= 1'b0;
            r_dbl_conf <= 1'b0;
            r_click    <= '0;
            r_double   <= '0;
            r_long     <= '0;
            r_out_vld  <= 1'b0;
            r_event    <= bced_pkg::EV_NONE;
        end else begin
            if (o_take) begin
                r_phase    <= n_phase;
                r_mark     <= n_mark;
                r_start    <= n_start;
                r_pending  <= n_pending;
                r_dbl_conf <= n_dbl_conf;
                r_click    <= n_click;
                r_double   <= n_double;
                r_long     <= n_long;
                r_event    <= n_event;
                r_out_vld  <= 1'b1;
            end else if (i_ready) begin
                r_out_vld  <= 1'b0;
            end
        end
    end

    // Counters double as the result totals
    assign o_valid              = r_out_vld;
    assign o_event_code         = r_event;
    assign o_click_total        = r_click;
    assign o_double_click_total = r_double;
    assign o_long_press_total   = r_long;

endmodule

FILE: src/button_click_event_detector.sv
// ============================================================================
// button_click_event_detector
// Debounced button event detector with click, double-click and long press.
// ============================================================================
// Each transfer on the input channel is one button sample (pin level, 32-bit
// millisecond timestamp, counter-clear flag) and yields exactly one result:
// an event code and the three event totals after that sample. A sample goes
// through the input register, then the result register, and a new sample is
// accepted every cycle unless the result channel stalls; the state machine
// update is combinational. Thresholds and pin polarity sit in APB
// registers at byte addresses 0x0 (debounce), 0x4 (long press), 0x8 (double
// click window) and 0xC (active low); write them only while no samples are
// in flight. Elapsed times wrap modulo 2^32.
// ============================================================================
module button_click_event_detector (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // APB configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bced_pkg::AddrW-1:0]  paddr,
    input  logic [bced_pkg::DataW-1:0]  pwdata,
    output logic [bced_pkg::DataW-1:0]  prdata,
    output logic                        pready,
    // Sample channel
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_pin_level,
    input  logic [bced_pkg::TimeW-1:0]  i_time_ms,
    input  logic                        i_clear_counts,
    // Result channel
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [bced_pkg::EventW-1:0] o_event_code,
    output logic [bced_pkg::CountW-1:0] o_click_total,
    output logic [bced_pkg::CountW-1:0] o_double_click_total,
    output logic [bced_pkg::CountW-1:0] o_long_press_total
);

    bced_pkg::t_cfg    cfg;
    bced_pkg::t_sample sample;
    logic              sample_vld;
    logic              take;

    // Configuration registers
    bced_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Input register
    bced_in_stage u_in (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_pin_level    (i_pin_level),
        .i_time_ms      (i_time_ms),
        .i_clear_counts (i_clear_counts),
        .o_vld          (sample_vld),
        .o_sample       (sample),
        .i_take         (take)
    );

    // State machine and result register
    bced_core u_core (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg                (cfg),
        .i_vld                (sample_vld),
        .i_sample             (sample),
        .o_take               (take),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_event_code         (o_event_code),
        .o_click_total        (o_click_total),
        .o_double_click_total (o_double_click_total),
        .o_long_press_total   (o_long_press_total)
    );

endmodule
